// ----- rtl/core/pra_pkg.sv -----
// shared types, constants and rounding helpers for the physical region allocator
// no dependencies; imported by every module of the block
`default_nettype none

package pra_pkg;

  // table geometry and address space
  localparam int MAX_REGIONS = 32;
  localparam int PAGE_SHIFT  = 12;
  localparam int ADDR_BITS   = 48;

  localparam int AW = ADDR_BITS;       // base width
  localparam int EW = ADDR_BITS + 1;   // exclusive end / length width
  localparam int XW = ADDR_BITS + 2;   // width of unrounded sums
  localparam int CW = $clog2(MAX_REGIONS + 1);
  localparam int IW = $clog2(MAX_REGIONS);

  localparam logic [XW-1:0] PG_LOW  = (XW'(1) << PAGE_SHIFT) - XW'(1);
  localparam logic [XW-1:0] PG_MASK = ~PG_LOW;
  localparam logic [XW-1:0] LIMIT   = XW'(1) << ADDR_BITS;

  // request types
  localparam logic [1:0] REQ_ADD   = 2'd0;
  localparam logic [1:0] REQ_RESV  = 2'd1;
  localparam logic [1:0] REQ_TEST  = 2'd2;
  localparam logic [1:0] REQ_ALLOC = 2'd3;

  // result status codes
  localparam logic [1:0] ST_OK    = 2'd0;
  localparam logic [1:0] ST_FULL  = 2'd1;
  localparam logic [1:0] ST_NOSPC = 2'd2;

  // table select
  localparam logic TBL_MEM = 1'b0;
  localparam logic TBL_RES = 1'b1;

  typedef struct packed {
    logic [1:0]    req_type;
    logic [AW-1:0] addr;
    logic [AW-1:0] length;
    logic [5:0]    align_log2;
    logic [AW-1:0] ceiling;
  } req_t;

  typedef struct packed {
    logic [1:0]    status;
    logic          hit;
    logic [AW-1:0] alloc_addr;
    logic [AW-1:0] mem_start;
    logic [EW-1:0] mem_end;
    logic [EW-1:0] mem_total;
    logic [5:0]    mem_count;
  } res_t;

  // datapath commands
  typedef enum logic [4:0] {
    OP_NONE, OP_LOAD, OP_TOUCH_STEP, OP_MERGE_INIT, OP_MERGE_STEP, OP_MERGE_DONE,
    OP_FIND_STEP, OP_SHIFT_INIT, OP_SHIFT_STEP, OP_PLACE, OP_REJECT, OP_TEST_STEP,
    OP_NOSPACE, OP_A_INIT, OP_A_LOAD, OP_A_CHK, OP_A_CEND, OP_SCAN_INIT, OP_A_SCAN,
    OP_A_STEP, OP_A_RESV, OP_SUM_INIT, OP_SUM_STEP, OP_DONE
  } dp_op_e;

  // datapath status back to the controller
  typedef struct packed {
    logic [1:0] req_type;
    logic       empty;
    logic       scan_end;
    logic       touch;
    logic       full;
    logic       find_stop;
    logic       shift_done;
    logic       hit_now;
    logic       mi_zero;
    logic       fit;
    logic       cand_ok;
    logic       conflict;
    logic       cbase_small;
  } dp_stat_t;

  function automatic logic [XW-1:0] pg_down(input logic [XW-1:0] x);
    return x & PG_MASK;
  endfunction

  function automatic logic [XW-1:0] pg_up(input logic [XW-1:0] x);
    return (x + PG_LOW) & PG_MASK;
  endfunction

  function automatic logic [EW-1:0] sat_end(input logic [XW-1:0] x);
    logic [XW-1:0] r;
    r = (x > LIMIT) ? LIMIT : x;
    return r[EW-1:0];
  endfunction

  // clear the low lg bits
  function automatic logic [XW-1:0] al_down(input logic [XW-1:0] x, input logic [5:0] lg);
    logic [XW-1:0] m;
    for (int k = 0; k < XW; k++) begin
      m[k] = (k >= int'(lg));
    end
    return x & m;
  endfunction

endpackage

`default_nettype wire

// ----- rtl/core/pra_ctrl.sv -----
// sequencing state machine for the physical region allocator
// depends on pra_pkg; drives pra_dp through command and status only
`default_nettype none

module pra_ctrl import pra_pkg::*; (
  input  wire logic     clk_i,
  input  wire logic     rst_ni,
  input  wire logic     start,
  output logic          busy,
  input  wire dp_stat_t stat_i,
  output dp_op_e        op_o
);

  typedef enum logic [4:0] {
    S_IDLE, S_DISP, S_INS_CHK, S_TOUCH, S_INS_DEC, S_MERGE, S_FIND, S_SHIFT,
    S_TEST, S_A_NEXT, S_A_CHK, S_A_CEND, S_A_GATE, S_A_SCAN, S_A_CONF,
    S_SUM0, S_SUM
  } state_e;

  state_e state_q, state_d;

  assign busy = (state_q != S_IDLE);

  // next state and command
  always_comb begin
    state_d = state_q;
    op_o    = OP_NONE;
    case (state_q)
      S_IDLE: begin
        if (start) begin
          op_o    = OP_LOAD;
          state_d = S_DISP;
        end
      end
      S_DISP: begin
        if (stat_i.req_type == REQ_TEST) begin
          state_d = S_TEST;
        end else if (stat_i.req_type == REQ_ALLOC) begin
          op_o    = OP_A_INIT;
          state_d = S_A_NEXT;
        end else begin
          state_d = S_INS_CHK;
        end
      end
      S_INS_CHK: begin
        state_d = stat_i.empty ? S_SUM0 : S_TOUCH;
      end
      S_TOUCH: begin
        if (stat_i.scan_end) begin
          state_d = S_INS_DEC;
        end else begin
          op_o = OP_TOUCH_STEP;
        end
      end
      S_INS_DEC: begin
        if (!stat_i.touch && stat_i.full) begin
          op_o    = OP_REJECT;
          state_d = S_SUM0;
        end else begin
          op_o    = OP_MERGE_INIT;
          state_d = S_MERGE;
        end
      end
      S_MERGE: begin
        if (stat_i.scan_end) begin
          op_o    = OP_MERGE_DONE;
          state_d = S_FIND;
        end else begin
          op_o = OP_MERGE_STEP;
        end
      end
      S_FIND: begin
        if (stat_i.find_stop) begin
          op_o    = OP_SHIFT_INIT;
          state_d = S_SHIFT;
        end else begin
          op_o = OP_FIND_STEP;
        end
      end
      S_SHIFT: begin
        if (stat_i.shift_done) begin
          op_o    = OP_PLACE;
          state_d = S_SUM0;
        end else begin
          op_o = OP_SHIFT_STEP;
        end
      end
      S_TEST: begin
        if (stat_i.scan_end) begin
          state_d = S_SUM0;
        end else begin
          op_o = OP_TEST_STEP;
          if (stat_i.hit_now) state_d = S_SUM0;
        end
      end
      S_A_NEXT: begin
        if (stat_i.mi_zero) begin
          op_o    = OP_NOSPACE;
          state_d = S_SUM0;
        end else begin
          op_o    = OP_A_LOAD;
          state_d = S_A_CHK;
        end
      end
      S_A_CHK: begin
        op_o    = OP_A_CHK;
        state_d = stat_i.fit ? S_A_CEND : S_A_NEXT;
      end
      S_A_CEND: begin
        op_o    = OP_A_CEND;
        state_d = S_A_GATE;
      end
      S_A_GATE: begin
        if (stat_i.cand_ok) begin
          op_o    = OP_SCAN_INIT;
          state_d = S_A_SCAN;
        end else begin
          state_d = S_A_NEXT;
        end
      end
      S_A_SCAN: begin
        if (stat_i.scan_end) begin
          op_o    = OP_A_RESV;
          state_d = S_INS_CHK;
        end else begin
          op_o = OP_A_SCAN;
          if (stat_i.conflict) state_d = S_A_CONF;
        end
      end
      S_A_CONF: begin
        if (stat_i.cbase_small) begin
          state_d = S_A_NEXT;
        end else begin
          op_o    = OP_A_STEP;
          state_d = S_A_CEND;
        end
      end
      S_SUM0: begin
        op_o    = OP_SUM_INIT;
        state_d = S_SUM;
      end
      S_SUM: begin
        if (stat_i.scan_end) begin
          op_o    = OP_DONE;
          state_d = S_IDLE;
        end else begin
          op_o = OP_SUM_STEP;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  // state register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

endmodule

`default_nettype wire

// ----- rtl/core/pra_dp.sv -----
// range tables, working registers and result register of the allocator
// depends on pra_pkg; commanded by pra_ctrl
`default_nettype none

module pra_dp import pra_pkg::*; (
  input  wire logic   clk_i,
  input  wire logic   rst_ni,
  input  wire dp_op_e op_i,
  input  wire req_t   req_i,
  output dp_stat_t    stat_o,
  output logic        res_valid_o,
  output res_t        res_o
);

  // range tables
  logic [AW-1:0] mem_base_q [MAX_REGIONS];
  logic [EW-1:0] mem_end_q  [MAX_REGIONS];
  logic [EW-1:0] mem_len_q  [MAX_REGIONS];
  logic [AW-1:0] res_base_q [MAX_REGIONS];
  logic [EW-1:0] res_end_q  [MAX_REGIONS];

  req_t            req_q;
  logic            sel_q, touch_q, cand_ok_q, hit_q, out_valid_q, shift_q;
  logic [CW-1:0]   idx_q, wr_q, mi_q, mcnt_q, rcnt_q;
  logic [EW-1:0]   cur_b_q, cur_e_q, size_q, lo_q, hi_q, cand_q, cbase_q;
  logic [EW:0]     cend_q;
  logic [1:0]      status_q;
  logic [AW-1:0]   where_q, start_q;
  logic [EW-1:0]   end_q, total_q;
  res_t            res_q;

  logic [CW-1:0]   cnt_sel, mi_dec, shift_ra;
  logic [IW-1:0]   mem_ra, res_ra, wa;
  logic [AW-1:0]   m_rb, r_rb, s_rb, wb;
  logic [EW-1:0]   m_re, m_len, r_re, s_re, we, wl, ceil_x, hi_new, hi_lo;
  logic            touch_now, hit_now, fit, conflict_now, wr_cond, mem_we, res_we;
  logic [XW-1:0]   in_sum, cand_sum;

  assign cnt_sel  = (sel_q == TBL_RES) ? rcnt_q : mcnt_q;
  assign mi_dec   = mi_q - CW'(1);
  assign shift_ra = wr_q - CW'(1);

  // read ports, one address per table, taken from registers only
  // memory table is read at the allocation cursor while the reserved table is selected
  assign mem_ra = (sel_q == TBL_RES) ? mi_dec[IW-1:0] :
                  shift_q            ? shift_ra[IW-1:0] : idx_q[IW-1:0];
  assign res_ra = shift_q ? shift_ra[IW-1:0] : idx_q[IW-1:0];

  assign m_rb  = mem_base_q[mem_ra];
  assign m_re  = mem_end_q[mem_ra];
  assign m_len = mem_len_q[mem_ra];
  assign r_rb  = res_base_q[res_ra];
  assign r_re  = res_end_q[res_ra];
  assign s_rb  = (sel_q == TBL_RES) ? r_rb : m_rb;
  assign s_re  = (sel_q == TBL_RES) ? r_re : m_re;

  // compares
  assign touch_now    = !((s_re < cur_b_q) || (cur_e_q < {1'b0, s_rb}));
  assign hit_now      = ({1'b0, req_q.addr} >= {1'b0, r_rb}) && ({1'b0, req_q.addr} < r_re);
  assign hi_lo        = hi_q - lo_q;
  assign fit          = (hi_q > lo_q) && (hi_lo >= size_q);
  assign conflict_now = (cand_q < r_re) && ({2'b00, r_rb} < cend_q);
  assign ceil_x       = {1'b0, req_q.ceiling};
  assign hi_new       = (ceil_x < m_re) ? ceil_x : m_re;
  assign in_sum       = XW'(req_i.addr) + XW'(req_i.length);
  assign cand_sum     = XW'(cand_q) + XW'(size_q);

  // status to the controller
  always_comb begin
    stat_o.req_type    = req_q.req_type;
    stat_o.empty       = (cur_e_q <= cur_b_q);
    stat_o.scan_end    = (idx_q == cnt_sel);
    stat_o.touch       = touch_q;
    stat_o.full        = (cnt_sel >= CW'(MAX_REGIONS));
    stat_o.find_stop   = (idx_q == cnt_sel) || ({1'b0, s_rb} >= cur_b_q);
    stat_o.shift_done  = (wr_q == idx_q);
    stat_o.hit_now     = hit_now;
    stat_o.mi_zero     = (mi_q == '0);
    stat_o.fit         = fit;
    stat_o.cand_ok     = cand_ok_q;
    stat_o.conflict    = conflict_now;
    stat_o.cbase_small = (cbase_q < size_q);
  end

  // table write port
  assign wr_cond = (op_i == OP_PLACE) || (op_i == OP_SHIFT_STEP) ||
                   ((op_i == OP_MERGE_STEP) && !touch_now);
  assign mem_we  = wr_cond && (sel_q == TBL_MEM);
  assign res_we  = wr_cond && (sel_q == TBL_RES);
  assign wa      = (op_i == OP_PLACE) ? idx_q[IW-1:0] : wr_q[IW-1:0];
  assign wb      = (op_i == OP_PLACE) ? cur_b_q[AW-1:0] : s_rb;
  assign we      = (op_i == OP_PLACE) ? cur_e_q : s_re;
  assign wl      = (op_i == OP_PLACE) ? (cur_e_q - cur_b_q) : m_len;

  always_ff @(posedge clk_i) begin
    if (mem_we) begin
      mem_base_q[wa] <= wb;
      mem_end_q[wa]  <= we;
      mem_len_q[wa]  <= wl;
    end
    if (res_we) begin
      res_base_q[wa] <= wb;
      res_end_q[wa]  <= we;
    end
  end

  // working registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      req_q       <= '0;
      sel_q       <= TBL_MEM;
      touch_q     <= 1'b0;
      cand_ok_q   <= 1'b0;
      hit_q       <= 1'b0;
      shift_q     <= 1'b0;
      idx_q       <= '0;
      wr_q        <= '0;
      mi_q        <= '0;
      mcnt_q      <= '0;
      rcnt_q      <= '0;
      cur_b_q     <= '0;
      cur_e_q     <= '0;
      size_q      <= '0;
      lo_q        <= '0;
      hi_q        <= '0;
      cand_q      <= '0;
      cbase_q     <= '0;
      cend_q      <= '0;
      status_q    <= ST_OK;
      where_q     <= '0;
      start_q     <= '0;
      end_q       <= '0;
      total_q     <= '0;
      out_valid_q <= 1'b0;
      res_q       <= '0;
    end else begin
      out_valid_q <= (op_i == OP_DONE);
      case (op_i)
        OP_LOAD: begin
          req_q    <= req_i;
          idx_q    <= '0;
          touch_q  <= 1'b0;
          shift_q  <= 1'b0;
          status_q <= ST_OK;
          hit_q    <= 1'b0;
          where_q  <= '0;
          size_q   <= EW'(pg_up(XW'(req_i.length)));
          if (req_i.req_type == REQ_ADD) begin
            sel_q   <= TBL_MEM;
            cur_b_q <= EW'(pg_up(XW'(req_i.addr)));
            cur_e_q <= sat_end(pg_down(in_sum));
          end else begin
            sel_q   <= TBL_RES;
            cur_b_q <= EW'(pg_down(XW'(req_i.addr)));
            cur_e_q <= sat_end(pg_up(in_sum));
          end
        end
        OP_TOUCH_STEP: begin
          touch_q <= touch_q | touch_now;
          idx_q   <= idx_q + CW'(1);
        end
        OP_MERGE_INIT: begin
          idx_q <= '0;
          wr_q  <= '0;
        end
        OP_MERGE_STEP: begin
          if (touch_now) begin
            if ({1'b0, s_rb} < cur_b_q) cur_b_q <= {1'b0, s_rb};
            if (s_re > cur_e_q) cur_e_q <= s_re;
          end else begin
            wr_q <= wr_q + CW'(1);
          end
          idx_q <= idx_q + CW'(1);
        end
        OP_MERGE_DONE: begin
          if (sel_q == TBL_RES) rcnt_q <= wr_q;
          else mcnt_q <= wr_q;
          idx_q <= '0;
        end
        OP_FIND_STEP: begin
          idx_q <= idx_q + CW'(1);
        end
        OP_SHIFT_INIT: begin
          wr_q    <= cnt_sel;
          shift_q <= 1'b1;
        end
        OP_SHIFT_STEP: begin
          wr_q <= shift_ra;
        end
        OP_PLACE: begin
          shift_q <= 1'b0;
          if (sel_q == TBL_RES) rcnt_q <= rcnt_q + CW'(1);
          else mcnt_q <= mcnt_q + CW'(1);
        end
        OP_REJECT: begin
          status_q <= ST_FULL;
          where_q  <= '0;
        end
        OP_TEST_STEP: begin
          if (hit_now) hit_q <= 1'b1;
          idx_q <= idx_q + CW'(1);
        end
        OP_NOSPACE: begin
          status_q <= ST_NOSPC;
        end
        OP_A_INIT: begin
          mi_q  <= mcnt_q;
          sel_q <= TBL_RES;
        end
        OP_A_LOAD: begin
          mi_q <= mi_dec;
          lo_q <= {1'b0, m_rb};
          hi_q <= hi_new;
        end
        OP_A_CHK: begin
          if (fit) cand_q <= EW'(al_down(XW'(hi_q - size_q), req_q.align_log2));
        end
        OP_A_CEND: begin
          cend_q    <= cand_sum[EW:0];
          cand_ok_q <= (cand_q >= lo_q);
        end
        OP_SCAN_INIT: begin
          idx_q <= '0;
        end
        OP_A_SCAN: begin
          if (conflict_now) cbase_q <= {1'b0, r_rb};
          else idx_q <= idx_q + CW'(1);
        end
        OP_A_STEP: begin
          cand_q <= EW'(al_down(XW'(cbase_q - size_q), req_q.align_log2));
        end
        OP_A_RESV: begin
          cur_b_q <= EW'(pg_down(XW'(cand_q)));
          cur_e_q <= sat_end(pg_up(cand_sum));
          sel_q   <= TBL_RES;
          where_q <= cand_q[AW-1:0];
          idx_q   <= '0;
          touch_q <= 1'b0;
        end
        OP_SUM_INIT: begin
          sel_q   <= TBL_MEM;
          idx_q   <= '0;
          total_q <= '0;
          start_q <= '0;
          end_q   <= '0;
        end
        OP_SUM_STEP: begin
          total_q <= total_q + m_len;
          if (idx_q == '0) start_q <= m_rb;
          end_q <= m_re;
          idx_q <= idx_q + CW'(1);
        end
        OP_DONE: begin
          res_q.status     <= status_q;
          res_q.hit        <= hit_q;
          res_q.alloc_addr <= where_q;
          res_q.mem_start  <= start_q;
          res_q.mem_end    <= end_q;
          res_q.mem_total  <= total_q;
          res_q.mem_count  <= 6'(mcnt_q);
        end
        default: begin
        end
      endcase
    end
  end

  assign res_valid_o = out_valid_q;
  assign res_o       = res_q;

endmodule

`default_nettype wire

// ----- rtl/core/physical_region_allocator.sv -----
// physical region allocator: sorted usable-memory and reserved range tables
// add/reserve: touch scan, merge, search and shift on the target table, then a memory sum pass
// test: scan of the reserved table until a hit or its end, then a memory sum pass
// allocation: one reserved-table scan per candidate, then an insert
// one request at a time: busy falls as the one-cycle result strobe rises; reset empties
// both tables (counts cleared), no clearing pass; depends on pra_pkg, pra_ctrl, pra_dp
`default_nettype none

module physical_region_allocator import pra_pkg::*; (
  input  wire logic clk_i,
  input  wire logic rst_ni,
  input  wire logic start,
  output logic      busy,
  input  wire req_t req_i,
  output logic      res_valid_o,
  output res_t      res_o
);

  dp_op_e   op;
  dp_stat_t stat;

  // sequencer
  pra_ctrl u_ctrl (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .start  (start),
    .busy   (busy),
    .stat_i (stat),
    .op_o   (op)
  );

  // tables and arithmetic
  pra_dp u_dp (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .op_i        (op),
    .req_i       (req_i),
    .stat_o      (stat),
    .res_valid_o (res_valid_o),
    .res_o       (res_o)
  );

endmodule

`default_nettype wire
